/* hw/rtl/jrca_pkg.sv */
// ----------------------------------------------------------------------------
// jrca_pkg
// Shared types, codes and helpers of the register cache allocator.
// ----------------------------------------------------------------------------
package jrca_pkg;

    localparam int SLOTS    = 5;
    localparam int AGE_BITS = 8;
    localparam int SLOT_W   = 3;
    localparam int GUEST_W  = 4;
    localparam int BIND_W   = GUEST_W + 1;
    localparam int WORD_W   = 32;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [BIND_W-1:0]   NO_GUEST   = BIND_W'(16);
    localparam logic [AGE_BITS-1:0] AGE_MAX    = '1;
    localparam logic [WORD_W-1:0]   WORD_LOAD  = 32'hE598_0000;
    localparam logic [WORD_W-1:0]   WORD_STORE = 32'hE588_0000;

    typedef enum logic [2:0] {
        OP_CLEAR = 3'd0,
        OP_GET   = 3'd1,
        OP_FIND  = 3'd2,
        OP_MARK  = 3'd3,
        OP_TICK  = 3'd4,
        OP_FLUSH = 3'd5,
        OP_BIND  = 3'd6,
        OP_AGE   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        MARK_UNUSED = 2'd0,
        MARK_CLEAN  = 2'd1,
        MARK_DIRTY  = 2'd2
    } t_mark;

    typedef enum logic [1:0] {
        KIND_REPLY = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_STORE = 2'd2
    } t_kind;

    typedef struct packed {
        t_op                op;
        logic [GUEST_W-1:0] guest;
        logic               no_guest;
        logic [SLOT_W-1:0]  slot;
        logic               slot_ok;
    } t_cmd;

    typedef struct packed {
        t_kind              kind;
        logic [SLOT_W-1:0]  host_slot;
        logic [GUEST_W-1:0] guest;
        logic               hit;
        logic               error;
        logic [WORD_W-1:0]  word;
        logic               last;
    } t_res;

    // host slot number of array entry i
    function automatic logic [SLOT_W-1:0] slot_id(input int i);
        return SLOT_W'(i + 1);
    endfunction

    // load/store word: guest register in bits 5:2, host slot in bits 14:12
    function automatic logic [WORD_W-1:0] ls_word(input logic [WORD_W-1:0]  base,
                                                  input logic [GUEST_W-1:0] guest,
                                                  input logic [SLOT_W-1:0]  slot);
        return base | {16'd0, 1'b0, slot, 6'd0, guest, 2'b00};
    endfunction

endpackage

/* hw/rtl/jrca_front.sv */
// ----------------------------------------------------------------------------
// jrca_front
// Accepts command items, decodes and range-checks them, and holds them in
// a short queue for the back end.
// ----------------------------------------------------------------------------
module jrca_front import jrca_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_opcode,
    input  logic [GUEST_W-1:0] i_guest_reg,
    input  logic               i_no_guest,
    input  logic [SLOT_W-1:0]  i_slot,
    output logic               o_cmd_valid,
    input  logic               i_cmd_pop,
    output t_cmd               o_cmd
);

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    t_cmd              w_cmd;
    logic              w_push;

    always_comb begin
        w_cmd.op       = t_op'(i_opcode);
        w_cmd.guest    = i_guest_reg;
        w_cmd.no_guest = i_no_guest;
        w_cmd.slot     = i_slot;
        w_cmd.slot_ok  = (i_slot != '0) && (int'(i_slot) <= SLOTS);
    end

    assign o_in_ready  = (r_cnt != QCNT_W'(QDEPTH));
    assign w_push      = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        unique case ({w_push, i_cmd_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

/* hw/rtl/jrca_back.sv */
// ----------------------------------------------------------------------------
// jrca_back
// Slot state and command sequencer: lookups, victim scan, write-back of
// dirty slots, and the output result register.
// ----------------------------------------------------------------------------
module jrca_back import jrca_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_EVICT = 5'b00100,
        ST_GRANT = 5'b01000,
        ST_FLUSH = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [SLOT_W-1:0]    r_idx, n_idx;
    logic [SLOT_W-1:0]    r_vic, n_vic;
    logic [AGE_BITS-1:0]  r_best, n_best;
    t_mark                r_mark [SLOTS];
    t_mark                n_mark [SLOTS];
    logic [BIND_W-1:0]    r_bind [SLOTS];
    logic [BIND_W-1:0]    n_bind [SLOTS];
    logic [AGE_BITS-1:0]  r_age  [SLOTS];
    logic [AGE_BITS-1:0]  n_age  [SLOTS];
    t_res                 r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    t_cmd                 c;
    logic                 out_free;
    logic [SLOTS-1:0]     hit_vec, db_vec;
    logic                 hit_any, free_any, temp_any;
    logic [SLOT_W-1:0]    hit_idx, free_idx, temp_idx;
    logic                 s_used, idx_db, vic_db, db_above, db_any;
    logic [AGE_BITS-1:0]  idx_age;
    logic [GUEST_W-1:0]   idx_guest, vic_guest;
    logic                 do_grant, do_clear;
    logic [SLOT_W-1:0]    grant_slot;

    function automatic logic [AGE_BITS-1:0] age_up(input logic [AGE_BITS-1:0] a);
        return (a == AGE_MAX) ? a : a + 1'b1;
    endfunction

    function automatic t_res mk_res(input t_kind k, input logic [SLOT_W-1:0] hs,
                                    input logic [GUEST_W-1:0] g, input logic h,
                                    input logic e, input logic [WORD_W-1:0] w,
                                    input logic l);
        t_res r;
        r.kind      = k;
        r.host_slot = hs;
        r.guest     = g;
        r.hit       = h;
        r.error     = e;
        r.word      = w;
        r.last      = l;
        return r;
    endfunction

    assign out_free    = !r_out_valid || i_res_ready;
    assign c           = (r_state == ST_IDLE) ? i_cmd : r_cmd;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // per-slot compares and selections
    always_comb begin
        hit_any   = 1'b0;
        free_any  = 1'b0;
        temp_any  = 1'b0;
        hit_idx   = '0;
        free_idx  = '0;
        temp_idx  = '0;
        s_used    = 1'b0;
        idx_db    = 1'b0;
        vic_db    = 1'b0;
        db_above  = 1'b0;
        idx_age   = '0;
        idx_guest = '0;
        vic_guest = '0;
        for (int i = 0; i < SLOTS; i++) begin
            hit_vec[i] = (r_mark[i] != MARK_UNUSED) && (r_bind[i] == {1'b0, c.guest});
            db_vec[i]  = (r_mark[i] == MARK_DIRTY) && (r_bind[i] != NO_GUEST);
            // lookup returns the lowest matching slot
            if (hit_vec[i] && !hit_any) begin
                hit_any = 1'b1;
                hit_idx = slot_id(i);
            end
            if (r_mark[i] == MARK_UNUSED) begin
                free_any = 1'b1;
                free_idx = slot_id(i);
            end
            if ((r_age[i] != '0) && (r_bind[i] == NO_GUEST)) begin
                temp_any = 1'b1;
                temp_idx = slot_id(i);
            end
            if (slot_id(i) == c.slot && r_mark[i] != MARK_UNUSED) begin
                s_used = 1'b1;
            end
            if (slot_id(i) == r_idx) begin
                idx_db    = db_vec[i];
                idx_age   = r_age[i];
                idx_guest = r_bind[i][GUEST_W-1:0];
            end
            if (slot_id(i) == r_vic) begin
                vic_db    = db_vec[i];
                vic_guest = r_bind[i][GUEST_W-1:0];
            end
            if (db_vec[i] && slot_id(i) > r_idx) begin
                db_above = 1'b1;
            end
        end
        db_any = |db_vec;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_vic       = r_vic;
        n_best      = r_best;
        n_mark      = r_mark;
        n_bind      = r_bind;
        n_age       = r_age;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_res_ready;
        o_cmd_pop   = 1'b0;
        do_grant    = 1'b0;
        do_clear    = 1'b0;
        grant_slot  = r_vic;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop   = 1'b1;
                    n_cmd       = i_cmd;
                    n_out_valid = 1'b1;
                    unique case (c.op)
                        OP_CLEAR: begin
                            do_clear = 1'b1;
                            n_out = mk_res(KIND_REPLY, '0, '0, 1'b0, 1'b0, '0, 1'b1);
                        end
                        OP_GET: begin
                            priority if (!c.no_guest && hit_any) begin
                                for (int i = 0; i < SLOTS; i++) begin
                                    if (slot_id(i) == hit_idx) begin
                                        n_age[i] = '0;
                                    end
                                end
                                n_out = mk_res(KIND_REPLY, hit_idx, c.guest, 1'b1, 1'b0,
                                               '0, 1'b1);
                            end else if (free_any) begin
                                do_grant   = 1'b1;
                                grant_slot = free_idx;
                            end else if (temp_any) begin
                                do_grant   = 1'b1;
                                grant_slot = temp_idx;
                            end else begin
                                // no result yet: scan ages for the victim
                                n_out_valid = r_out_valid && !i_res_ready;
                                n_state     = ST_SCAN;
                                n_idx       = SLOT_W'(1);
                                n_vic       = SLOT_W'(1);
                                n_best      = '0;
                            end
                        end
                        OP_FIND: begin
                            n_out = mk_res(KIND_REPLY, hit_idx, c.guest, hit_any, 1'b0,
                                           '0, 1'b1);
                        end
                        OP_MARK: begin
                            if (c.slot_ok && s_used) begin
                                for (int i = 0; i < SLOTS; i++) begin
                                    if (slot_id(i) == c.slot) begin
                                        n_mark[i] = MARK_DIRTY;
                                    end
                                end
                                n_out = mk_res(KIND_REPLY, c.slot, '0, 1'b0, 1'b0, '0, 1'b1);
                            end else begin
                                n_out = mk_res(KIND_REPLY, c.slot, '0, 1'b0, 1'b1, '0, 1'b1);
                            end
                        end
                        OP_TICK: begin
                            for (int i = 0; i < SLOTS; i++) begin
                                if (r_mark[i] != MARK_UNUSED) begin
                                    if (r_bind[i] == NO_GUEST) begin
                                        n_mark[i] = MARK_UNUSED;
                                    end else begin
                                        n_age[i] = age_up(r_age[i]);
                                    end
                                end
                            end
                            n_out = mk_res(KIND_REPLY, '0, '0, 1'b0, 1'b0, '0, 1'b1);
                        end
                        OP_FLUSH: begin
                            if (db_any) begin
                                n_out_valid = r_out_valid && !i_res_ready;
                                n_state     = ST_FLUSH;
                                n_idx       = SLOT_W'(1);
                            end else begin
                                do_clear = 1'b1;
                                n_out = mk_res(KIND_REPLY, '0, '0, 1'b0, 1'b0, '0, 1'b1);
                            end
                        end
                        OP_BIND: begin
                            if (c.slot_ok) begin
                                for (int i = 0; i < SLOTS; i++) begin
                                    if (slot_id(i) == hit_idx) begin
                                        n_bind[i] = NO_GUEST;
                                    end
                                end
                                // target written last so it wins when it held the register
                                for (int i = 0; i < SLOTS; i++) begin
                                    if (slot_id(i) == c.slot) begin
                                        n_bind[i] = {1'b0, c.guest};
                                        n_mark[i] = MARK_DIRTY;
                                    end
                                end
                            end
                            n_out = mk_res(KIND_REPLY, c.slot, c.guest, 1'b0, 1'b0, '0, 1'b1);
                        end
                        OP_AGE: begin
                            for (int i = 0; i < SLOTS; i++) begin
                                if (slot_id(i) == c.slot) begin
                                    n_age[i] = age_up(r_age[i]);
                                end
                            end
                            n_out = mk_res(KIND_REPLY, c.slot, '0, 1'b0, 1'b0, '0, 1'b1);
                        end
                        default: begin
                            n_out = mk_res(KIND_REPLY, '0, '0, 1'b0, 1'b0, '0, 1'b1);
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // oldest slot, ties to the higher one
                if (idx_age >= r_best) begin
                    n_best = idx_age;
                    n_vic  = r_idx;
                end
                if (int'(r_idx) == SLOTS) begin
                    n_state = ST_EVICT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_EVICT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (vic_db) begin
                        n_out = mk_res(KIND_STORE, r_vic, vic_guest, 1'b0, 1'b0,
                                       ls_word(WORD_STORE, vic_guest, r_vic), 1'b0);
                        n_state = ST_GRANT;
                    end else begin
                        do_grant = 1'b1;
                        n_state  = ST_IDLE;
                    end
                end
            end
            ST_GRANT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    do_grant    = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (idx_db) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out = mk_res(KIND_STORE, r_idx, idx_guest, 1'b0, 1'b0,
                                       ls_word(WORD_STORE, idx_guest, r_idx), !db_above);
                        if (!db_above) begin
                            do_clear = 1'b1;
                            n_state  = ST_IDLE;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (do_grant) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_id(i) == grant_slot) begin
                    n_mark[i] = MARK_CLEAN;
                    n_bind[i] = c.no_guest ? NO_GUEST : {1'b0, c.guest};
                    n_age[i]  = '0;
                end
            end
            if (c.no_guest) begin
                n_out = mk_res(KIND_REPLY, grant_slot, '0, 1'b0, 1'b0, '0, 1'b1);
            end else begin
                n_out = mk_res(KIND_LOAD, grant_slot, c.guest, 1'b0, 1'b0,
                               ls_word(WORD_LOAD, c.guest, grant_slot), 1'b1);
            end
        end

        if (do_clear) begin
            for (int i = 0; i < SLOTS; i++) begin
                n_mark[i] = MARK_UNUSED;
                n_bind[i] = NO_GUEST;
                n_age[i]  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_mark[i] <= MARK_UNUSED;
                r_bind[i] <= NO_GUEST;
                r_age[i]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_mark      <= n_mark;
            r_bind      <= n_bind;
            r_age       <= n_age;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_idx  <= n_idx;
        r_vic  <= n_vic;
        r_best <= n_best;
        r_out  <= n_out;
    end

endmodule

/* hw/rtl/jit_register_cache_allocator_unit.sv */
// ----------------------------------------------------------------------------
// jit_register_cache_allocator_unit
// Host register cache allocator for a block translator. Commands enter a
// two-entry queue and a sequencer carries them out against the slot state
// (mark, binding and age per host slot), giving one to several result items,
// the final one flagged by last. A get that finds no cached, unused or aged
// temporary slot scans the slot ages one slot per cycle before its optional
// store of a dirty bound victim and its load, or its reply when it binds no
// guest. A flush walks the slots one per cycle, waiting while a store is
// stalled, up to the last dirty bound slot and gives one store per such slot.
// The output register decouples result delivery from command intake.
// ----------------------------------------------------------------------------
module jit_register_cache_allocator_unit import jrca_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_opcode,
    input  logic [GUEST_W-1:0] i_guest_reg,
    input  logic               i_no_guest,
    input  logic [SLOT_W-1:0]  i_slot,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_kind,
    output logic [SLOT_W-1:0]  o_host_slot,
    output logic [GUEST_W-1:0] o_guest_number,
    output logic               o_hit,
    output logic               o_error,
    output logic [WORD_W-1:0]  o_machine_word,
    output logic               o_last
);

    logic cmd_valid, cmd_pop;
    t_cmd cmd;
    t_res res;

    jrca_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_guest_reg (i_guest_reg),
        .i_no_guest  (i_no_guest),
        .i_slot      (i_slot),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd)
    );

    jrca_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (o_out_valid),
        .i_res_ready (i_out_ready),
        .o_res       (res)
    );

    assign o_kind         = res.kind;
    assign o_host_slot    = res.host_slot;
    assign o_guest_number = res.guest;
    assign o_hit          = res.hit;
    assign o_error        = res.error;
    assign o_machine_word = res.word;
    assign o_last         = res.last;

endmodule

/* hw/rtl/jrca_checker.sv */
// ----------------------------------------------------------------------------
// jrca_checker
// Port-level checks of the register cache allocator result stream.
// ----------------------------------------------------------------------------
module jrca_checker import jrca_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [1:0]         o_kind,
    input logic [SLOT_W-1:0]  o_host_slot,
    input logic               o_hit,
    input logic               o_error,
    input logic [WORD_W-1:0]  o_machine_word,
    input logic               o_last
);

    // stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_machine_word)
            && $stable(o_last))
        else $error("result item changed while stalled");

    a_reply_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_REPLY |-> o_machine_word == '0)
        else $error("plain reply carries a machine word");

    a_flag_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_hit || o_error) |-> o_last && o_kind == KIND_REPLY)
        else $error("hit or error flag on a non-final or non-reply item");

    a_load_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_LOAD |-> o_last && !o_hit && o_host_slot != '0)
        else $error("load item malformed");

endmodule

bind jit_register_cache_allocator_unit jrca_checker u_jrca_checker (.*);
